/* design/alfe_pkg.sv */
`timescale 1ns / 1ps
// types, constants and the gamma table shared by the led frame encoder
package alfe_pkg;

	localparam int BITS_PER_LED = 24;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 10;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;
	localparam int GROUP_SIZE = 16;

	localparam logic [5:0] RST_ACTIVE_LEDS = 6'd18;
	localparam logic [9:0] RST_RESET_SLOTS = 10'd400;
	localparam logic [7:0] RST_ONE_CODE = 8'd10;
	localparam logic [7:0] RST_ZERO_CODE = 8'd5;
	localparam logic [7:0] RST_END_CODE = 8'd100;

	typedef enum logic [1:0] {
		OP_SET = 2'd0,
		OP_FLUSH_CHANGED = 2'd1,
		OP_FLUSH = 2'd2,
		OP_TICK = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_ACTIVE_LEDS = 3'd0,
		REG_RESET_SLOTS = 3'd1,
		REG_ONE_CODE = 3'd2,
		REG_ZERO_CODE = 3'd3,
		REG_END_CODE = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		SLOT_IDLE,
		SLOT_ZERO,
		SLOT_BIT,
		SLOT_END
	} slot_mode_t;

	typedef enum logic [1:0] {
		BK_FETCH,
		BK_SET_WR,
		BK_FLUSH_EVAL,
		BK_TICK_OUT
	} back_state_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] led_pos;
		logic [23:0] color_rgb;
	} item_t;

	typedef struct packed {
		logic [7:0] duty_code;
		logic sending;
		logic last;
	} result_t;

	typedef struct packed {
		logic [5:0] led_count;
		logic [9:0] reset_slots;
		logic [7:0] one_code;
		logic [7:0] zero_code;
		logic [7:0] end_code;
	} cfg_t;

	typedef struct packed {
		op_t kind;
		logic [7:0] idx;
		logic [23:0] grb;
	} cmd_t;

	localparam logic [7:0] GAMMA_LUT [256] = '{
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
		8'd1, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2,
		8'd2, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3,
		8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 8'd5, 8'd5, 8'd5,
		8'd5, 8'd6, 8'd6, 8'd6, 8'd6, 8'd7, 8'd7, 8'd7,
		8'd7, 8'd8, 8'd8, 8'd8, 8'd9, 8'd9, 8'd9, 8'd10,
		8'd10, 8'd10, 8'd11, 8'd11, 8'd11, 8'd12, 8'd12, 8'd13,
		8'd13, 8'd13, 8'd14, 8'd14, 8'd15, 8'd15, 8'd16, 8'd16,
		8'd17, 8'd17, 8'd18, 8'd18, 8'd19, 8'd19, 8'd20, 8'd20,
		8'd21, 8'd21, 8'd22, 8'd22, 8'd23, 8'd24, 8'd24, 8'd25,
		8'd25, 8'd26, 8'd27, 8'd27, 8'd28, 8'd29, 8'd29, 8'd30,
		8'd31, 8'd32, 8'd32, 8'd33, 8'd34, 8'd35, 8'd35, 8'd36,
		8'd37, 8'd38, 8'd39, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43,
		8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50, 8'd50,
		8'd51, 8'd52, 8'd54, 8'd55, 8'd56, 8'd57, 8'd58, 8'd59,
		8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd66, 8'd67, 8'd68,
		8'd69, 8'd70, 8'd72, 8'd73, 8'd74, 8'd75, 8'd77, 8'd78,
		8'd79, 8'd81, 8'd82, 8'd83, 8'd85, 8'd86, 8'd87, 8'd89,
		8'd90, 8'd92, 8'd93, 8'd95, 8'd96, 8'd98, 8'd99, 8'd101,
		8'd102, 8'd104, 8'd105, 8'd107, 8'd109, 8'd110, 8'd112, 8'd114,
		8'd115, 8'd117, 8'd119, 8'd120, 8'd122, 8'd124, 8'd126, 8'd127,
		8'd129, 8'd131, 8'd133, 8'd135, 8'd137, 8'd138, 8'd140, 8'd142,
		8'd144, 8'd146, 8'd148, 8'd150, 8'd152, 8'd154, 8'd156, 8'd158,
		8'd160, 8'd162, 8'd164, 8'd167, 8'd169, 8'd171, 8'd173, 8'd175,
		8'd177, 8'd180, 8'd182, 8'd184, 8'd186, 8'd189, 8'd191, 8'd193,
		8'd196, 8'd198, 8'd200, 8'd203, 8'd205, 8'd208, 8'd210, 8'd213,
		8'd215, 8'd218, 8'd220, 8'd223, 8'd225, 8'd228, 8'd231, 8'd233,
		8'd236, 8'd239, 8'd241, 8'd244, 8'd247, 8'd249, 8'd252, 8'd255
	};

endpackage

/* design/alfe_stream_if.sv */
`timescale 1ns / 1ps
// valid/ready stream channel carrying one payload per transfer
interface alfe_stream_if #(
	parameter type payload_t = logic
) ();
	logic valid;
	logic ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* design/alfe_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module alfe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* design/alfe_front.sv */
`timescale 1ns / 1ps
// input side: accepts items, drops out-of-range sets, applies gamma
module alfe_front (
	input logic [5:0] led_count,
	input logic q_full,
	output logic push,
	output alfe_pkg::cmd_t push_cmd,
	alfe_stream_if.sink item
);
	import alfe_pkg::*;

	op_t op;
	logic in_range;

	assign op = op_t'(item.data.operation);
	assign in_range = item.data.led_pos < {2'b00, led_count};
	assign item.ready = !q_full;
	assign push = item.valid && !q_full && ((op != OP_SET) || in_range);

	assign push_cmd.kind = op;
	assign push_cmd.idx = item.data.led_pos;
	assign push_cmd.grb = {GAMMA_LUT[item.data.color_rgb[15:8]],
		GAMMA_LUT[item.data.color_rgb[23:16]],
		GAMMA_LUT[item.data.color_rgb[7:0]]};
endmodule

/* design/alfe_queue.sv */
`timescale 1ns / 1ps
// small command queue between the front and back parts
module alfe_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input alfe_pkg::cmd_t push_cmd,
	output logic full,
	input logic pop,
	output alfe_pkg::cmd_t head,
	output logic empty
);
	import alfe_pkg::*;

	cmd_t entries_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end
endmodule

/* design/alfe_back.sv */
`timescale 1ns / 1ps
// execution side: frame banks, change flags, slot sequencer and output register
module alfe_back #(
	parameter int MAX_LEDS = 32
) (
	input logic clk,
	input logic arst_n,
	input alfe_pkg::cfg_t cfg,
	input logic q_empty,
	input alfe_pkg::cmd_t q_head,
	output logic q_pop,
	alfe_stream_if.source result
);
	import alfe_pkg::*;

	localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int NUM_GROUPS = (MAX_LEDS + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam logic [4:0] BIT_TOP = 5'(BITS_PER_LED - 1);

	back_state_t state_q, state_d;

	logic [MAX_LEDS-1:0] pend_bank_q;
	logic [MAX_LEDS-1:0] shown_bank_q;
	logic [MAX_LEDS-1:0] valid_a_q;
	logic [MAX_LEDS-1:0] valid_b_q;
	logic [MAX_LEDS-1:0] differs_q;
	logic shown_known_q;
	logic busy_q;
	logic [10:0] slot_pos_q;

	logic [IDX_W-1:0] rd_addr_q;
	logic [23:0] set_grb_q;
	slot_mode_t mode_q;
	logic [4:0] bit_q;
	logic [NUM_GROUPS-1:0] group_any_q;

	logic res_vld_q;
	result_t res_q;

	// slot decode
	logic [10:0] bit_total;
	logic [10:0] q_off;
	logic before_bits;
	logic in_bits;
	logic [15:0] div_prod;
	logic [6:0] led_num;
	logic [10:0] led_base;
	logic [10:0] bit_rem;
	logic [8:0] led_wide;
	logic [IDX_W-1:0] tick_addr;
	logic [IDX_W-1:0] set_addr;
	slot_mode_t mode_d;

	logic [NUM_GROUPS*GROUP_SIZE-1:0] live_flags;
	logic [NUM_GROUPS-1:0] group_any_d;

	logic [IDX_W-1:0] raddr;
	logic [23:0] rdata_a;
	logic [23:0] rdata_b;
	logic [23:0] shown_word;
	logic tgt_bank;
	logic out_free;
	logic fetch;
	logic start_frame;
	logic set_write;
	logic tick_emit;
	result_t res_d;

	assign out_free = !res_vld_q || result.ready;
	assign fetch = (state_q == BK_FETCH) && !q_empty;

	assign bit_total = {1'b0, cfg.led_count, 4'b0} + {2'b0, cfg.led_count, 3'b0};
	assign q_off = slot_pos_q - {1'b0, cfg.reset_slots};
	assign before_bits = slot_pos_q < {1'b0, cfg.reset_slots};
	assign in_bits = q_off < bit_total;
	// divide by 24: shift by 3, then multiply by the reciprocal of 3
	assign div_prod = q_off[10:3] * 8'd171;
	assign led_num = div_prod[15:9];
	assign led_base = {led_num, 4'b0} + {1'b0, led_num, 3'b0};
	assign bit_rem = q_off - led_base;
	assign led_wide = {2'b00, led_num};
	assign tick_addr = led_wide[IDX_W-1:0];
	assign set_addr = q_head.idx[IDX_W-1:0];

	always_comb begin
		if (!busy_q) begin
			mode_d = SLOT_IDLE;
		end else if (before_bits) begin
			mode_d = SLOT_ZERO;
		end else if (in_bits) begin
			mode_d = SLOT_BIT;
		end else begin
			mode_d = SLOT_END;
		end
	end

	always_comb begin
		live_flags = '0;
		for (int i = 0; i < MAX_LEDS; i++) begin
			live_flags[i] = differs_q[i] && (9'(i) < {3'b000, cfg.led_count});
		end
		for (int g = 0; g < NUM_GROUPS; g++) begin
			group_any_d[g] = |live_flags[g*GROUP_SIZE +: GROUP_SIZE];
		end
	end

	assign raddr = (state_q == BK_FETCH) ?
		((q_head.kind == OP_TICK) ? tick_addr : set_addr) : rd_addr_q;

	assign shown_word = shown_bank_q[rd_addr_q] ?
		(valid_b_q[rd_addr_q] ? rdata_b : '0) :
		(valid_a_q[rd_addr_q] ? rdata_a : '0);
	assign tgt_bank = (pend_bank_q[rd_addr_q] == shown_bank_q[rd_addr_q]) ?
		!shown_bank_q[rd_addr_q] : pend_bank_q[rd_addr_q];

	alfe_ram #(.WIDTH(24), .DEPTH(MAX_LEDS)) u_bank_a (
		.clk(clk),
		.we(set_write && !tgt_bank),
		.waddr(rd_addr_q),
		.wdata(set_grb_q),
		.raddr(raddr),
		.rdata(rdata_a)
	);

	alfe_ram #(.WIDTH(24), .DEPTH(MAX_LEDS)) u_bank_b (
		.clk(clk),
		.we(set_write && tgt_bank),
		.waddr(rd_addr_q),
		.wdata(set_grb_q),
		.raddr(raddr),
		.rdata(rdata_b)
	);

	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		start_frame = 1'b0;
		set_write = 1'b0;
		tick_emit = 1'b0;
		case (state_q)
			BK_FETCH: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					case (q_head.kind)
						OP_SET: state_d = BK_SET_WR;
						OP_FLUSH_CHANGED: state_d = BK_FLUSH_EVAL;
						OP_FLUSH: start_frame = !busy_q;
						OP_TICK: state_d = BK_TICK_OUT;
						default: state_d = BK_FETCH;
					endcase
				end
			end
			BK_SET_WR: begin
				set_write = 1'b1;
				state_d = BK_FETCH;
			end
			BK_FLUSH_EVAL: begin
				start_frame = !busy_q && (!shown_known_q || (|group_any_q));
				state_d = BK_FETCH;
			end
			BK_TICK_OUT: begin
				if (out_free) begin
					tick_emit = 1'b1;
					state_d = BK_FETCH;
				end
			end
			default: state_d = BK_FETCH;
		endcase
	end

	always_comb begin
		case (mode_q)
			SLOT_IDLE: res_d = '0;
			SLOT_ZERO: res_d = '{duty_code: 8'd0, sending: 1'b1, last: 1'b0};
			SLOT_BIT: res_d = '{
				duty_code: shown_word[BIT_TOP - bit_q] ? cfg.one_code : cfg.zero_code,
				sending: 1'b1, last: 1'b0};
			SLOT_END: res_d = '{duty_code: cfg.end_code, sending: 1'b1, last: 1'b1};
			default: res_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_FETCH;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bank_q <= '0;
			shown_bank_q <= '0;
			valid_a_q <= '0;
			valid_b_q <= '0;
			differs_q <= '0;
			shown_known_q <= 1'b0;
			busy_q <= 1'b0;
			slot_pos_q <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (start_frame) begin
				shown_bank_q <= pend_bank_q;
				differs_q <= '0;
				shown_known_q <= 1'b1;
				busy_q <= 1'b1;
				slot_pos_q <= '0;
			end
			if (set_write) begin
				pend_bank_q[rd_addr_q] <= tgt_bank;
				if (tgt_bank) begin
					valid_b_q[rd_addr_q] <= 1'b1;
				end else begin
					valid_a_q[rd_addr_q] <= 1'b1;
				end
				differs_q[rd_addr_q] <= (set_grb_q != shown_word);
			end
			if (tick_emit) begin
				case (mode_q)
					SLOT_ZERO, SLOT_BIT: slot_pos_q <= slot_pos_q + 11'd1;
					SLOT_END: begin
						busy_q <= 1'b0;
						slot_pos_q <= '0;
					end
					default: slot_pos_q <= slot_pos_q;
				endcase
			end
			if (tick_emit) begin
				res_vld_q <= 1'b1;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fetch) begin
			rd_addr_q <= raddr;
			set_grb_q <= q_head.grb;
			mode_q <= mode_d;
			bit_q <= bit_rem[4:0];
			group_any_q <= group_any_d;
		end
		if (tick_emit) begin
			res_q <= res_d;
		end
	end

	assign result.valid = res_vld_q;
	assign result.data = res_q;
endmodule

/* design/addressable_led_frame_encoder_core.sv */
`timescale 1ns / 1ps
// top level of the addressable led frame encoder
//
// item channel (sink): operation, led_pos, color_rgb; result channel (source):
// duty_code, sending, last. set and both flushes give no result, every tick gives one.
// configuration: cfg_we with cfg_index and cfg_wdata writes one register per cycle.
// accepted items go through a 4-entry command queue into the back part, which works
// on one command at a time: a forced flush ends in its fetch state; a set or a tick
// then waits on the registered read of the frame bank ram, a flush-if-changed on its
// registered change flags. a tick passes the queue entry, the fetch registers and the
// tick output state before its result sits in the output register.
// reset loads the register defaults (18 leds, 400 reset slots, codes 10/5/100), a
// black frame, no change flags and an idle sequencer; no frame has been sent yet.
// while the receiver stalls the result holds in the output register, the next tick
// waits in the back part and holds up every command behind it, and item ready drops
// once the queue is full.
module addressable_led_frame_encoder_core #(
	parameter int MAX_LEDS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [alfe_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [alfe_pkg::CFG_DATA_W-1:0] cfg_wdata,
	alfe_stream_if.sink item,
	alfe_stream_if.source result
);
	import alfe_pkg::*;

	localparam int CNT_CAP = (MAX_LEDS < 63) ? MAX_LEDS : 63;

	logic [5:0] active_leds_q;
	logic [9:0] reset_slots_q;
	logic [7:0] one_code_q;
	logic [7:0] zero_code_q;
	logic [7:0] end_code_q;

	cfg_t cfg;
	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic q_pop;
	cmd_t q_head;
	logic q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_leds_q <= RST_ACTIVE_LEDS;
			reset_slots_q <= RST_RESET_SLOTS;
			one_code_q <= RST_ONE_CODE;
			zero_code_q <= RST_ZERO_CODE;
			end_code_q <= RST_END_CODE;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_ACTIVE_LEDS: active_leds_q <= cfg_wdata[5:0];
				REG_RESET_SLOTS: reset_slots_q <= cfg_wdata[9:0];
				REG_ONE_CODE: one_code_q <= cfg_wdata[7:0];
				REG_ZERO_CODE: zero_code_q <= cfg_wdata[7:0];
				REG_END_CODE: end_code_q <= cfg_wdata[7:0];
				default: end_code_q <= end_code_q;
			endcase
		end
	end

	assign cfg.led_count = (active_leds_q > 6'(CNT_CAP)) ? 6'(CNT_CAP) : active_leds_q;
	assign cfg.reset_slots = reset_slots_q;
	assign cfg.one_code = one_code_q;
	assign cfg.zero_code = zero_code_q;
	assign cfg.end_code = end_code_q;

	alfe_front u_front (
		.led_count(cfg.led_count),
		.q_full(q_full),
		.push(push),
		.push_cmd(push_cmd),
		.item(item)
	);

	alfe_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_cmd(push_cmd),
		.full(q_full),
		.pop(q_pop),
		.head(q_head),
		.empty(q_empty)
	);

	alfe_back #(.MAX_LEDS(MAX_LEDS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_empty(q_empty),
		.q_head(q_head),
		.q_pop(q_pop),
		.result(result)
	);
endmodule

/* design/alfe_checker.sv */
`timescale 1ns / 1ps
// port-level checks on the result channel, bound to the top level
module alfe_checker (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input alfe_pkg::result_t res_data
);
	import alfe_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	a_last_sending: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.last |-> res_data.sending)
		else $error("end slot outside a frame");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.sending |-> (res_data.duty_code == 8'd0) && !res_data.last)
		else $error("idle slot with nonzero code");
endmodule

bind addressable_led_frame_encoder_core alfe_checker u_alfe_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(result.valid),
	.res_ready(result.ready),
	.res_data(result.data)
);
